// ----- design/bsc_pkg.sv -----
`timescale 1ns / 1ps

package bsc_pkg;

  // field widths
  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int DT_W    = 26;
  localparam int TEMP_W  = 19;
  localparam int PRESS_W = 32;
  localparam int ACC_W   = 64;
  localparam int MUL_W   = 27;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SH_W    = 5;
  localparam int PC_W    = 5;
  localparam int IDX_W   = 3;

  // temperature thresholds in 0.01 degC
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -19'sd1500;

  // power-of-two divisors as shift amounts
  localparam logic [SH_W-1:0] DIV_TEMP_SH  = 5'd23;
  localparam logic [SH_W-1:0] OFF_TC_SH    = 5'd7;
  localparam logic [SH_W-1:0] SENS_TC_SH   = 5'd8;
  localparam logic [SH_W-1:0] DIV_PRESS_SH = 5'd21;
  localparam logic [SH_W-1:0] P_DIV_SH     = 5'd15;

  // dT^2 / 2^31 is taken from the product bits
  localparam int T2_SH = 31;
  // sens is multiplied as a low unsigned part and a high signed part
  localparam int SENS_SPLIT = 19;

  // calibration register indexes
  localparam logic [IDX_W-1:0] REG_SENS      = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENS_TC   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_TC = 3'd3;
  localparam logic [IDX_W-1:0] REG_TREF      = 3'd4;
  localparam logic [IDX_W-1:0] REG_TSENS     = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_tc;
    logic [COEF_W-1:0] offset_tc;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tsens;
  } coef_t;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_DT_C6,
    MUL_DT_DT,
    MUL_D_D,
    MUL_E_E,
    MUL_DT_C4,
    MUL_DT_C3,
    MUL_RAW_SLO,
    MUL_RAW_SHI
  } mul_sel_e;

  // datapath operations
  typedef enum logic [4:0] {
    ALU_NOP,
    ALU_DT,
    ALU_TEMP,
    ALU_CLR,
    ALU_T2,
    ALU_LD_P,
    ALU_X5,
    ALU_SPLIT5,
    ALU_E7,
    ALU_OFF_ADD,
    ALU_E11,
    ALU_SENS_ADD,
    ALU_BIAS_P,
    ALU_BIAS_A,
    ALU_OFF_SUB,
    ALU_OFF_SET,
    ALU_SENS_SUB,
    ALU_SENS_SET,
    ALU_ADD_PH,
    ALU_OUT_T,
    ALU_OUT_P
  } alu_op_e;

  // jump conditions
  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_KIND,
    JMP_WARM,
    JMP_NOT_COLD
  } jmp_e;

  typedef struct packed {
    mul_sel_e        mul;
    alu_op_e         alu;
    logic [SH_W-1:0] sh;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            done;
  } ctrl_t;

  // sequencer strobes toward the datapath
  typedef struct packed {
    logic accept;
    logic exec;
  } seq_t;

  // datapath flags toward the sequencer
  typedef struct packed {
    logic kind;
    logic warm;
    logic not_cold;
    logic out_busy;
  } stat_t;

endpackage

// ----- design/bsc_sequencer.sv -----
`timescale 1ns / 1ps

module bsc_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bsc_pkg::stat_t    stat_i,
  output bsc_pkg::ctrl_t    ctrl_o,
  output bsc_pkg::seq_t     seq_o
);

  localparam logic [bsc_pkg::PC_W-1:0] PC_DISPATCH = 5'd0;
  localparam logic [bsc_pkg::PC_W-1:0] PC_PRESS    = 5'd6;
  localparam logic [bsc_pkg::PC_W-1:0] PC_BASE     = 5'd16;

  localparam bsc_pkg::ctrl_t CTRL_NOP = '{
    mul:    bsc_pkg::MUL_NONE,
    alu:    bsc_pkg::ALU_NOP,
    sh:     '0,
    jmp:    bsc_pkg::JMP_NONE,
    target: '0,
    done:   1'b0
  };

  logic                      busy_q, busy_d;
  logic [bsc_pkg::PC_W-1:0]  pc_q, pc_d;
  bsc_pkg::ctrl_t            ctrl;
  logic                      hold;
  logic                      exec;
  logic                      accept;
  logic                      taken;

  // microprogram rom
  always_comb begin
    ctrl = CTRL_NOP;
    unique case (pc_q)
      // dispatch on item kind
      5'd0: begin
        ctrl.jmp    = bsc_pkg::JMP_KIND;
        ctrl.target = PC_PRESS;
      end
      // temperature: dT, dT*C6, rounding, TEMP, result
      5'd1: ctrl.alu = bsc_pkg::ALU_DT;
      5'd2: ctrl.mul = bsc_pkg::MUL_DT_C6;
      5'd3: begin
        ctrl.alu = bsc_pkg::ALU_BIAS_P;
        ctrl.sh  = bsc_pkg::DIV_TEMP_SH;
      end
      5'd4: begin
        ctrl.alu = bsc_pkg::ALU_TEMP;
        ctrl.sh  = bsc_pkg::DIV_TEMP_SH;
      end
      5'd5: begin
        ctrl.alu  = bsc_pkg::ALU_OUT_T;
        ctrl.done = 1'b1;
      end
      // pressure: clear corrections, skip them when warm
      5'd6: begin
        ctrl.alu    = bsc_pkg::ALU_CLR;
        ctrl.jmp    = bsc_pkg::JMP_WARM;
        ctrl.target = PC_BASE;
      end
      5'd7: ctrl.mul = bsc_pkg::MUL_DT_DT;
      5'd8: begin
        ctrl.alu = bsc_pkg::ALU_T2;
        ctrl.mul = bsc_pkg::MUL_D_D;
      end
      5'd9:  ctrl.alu = bsc_pkg::ALU_LD_P;
      5'd10: ctrl.alu = bsc_pkg::ALU_X5;
      5'd11: begin
        ctrl.alu    = bsc_pkg::ALU_SPLIT5;
        ctrl.mul    = bsc_pkg::MUL_E_E;
        ctrl.jmp    = bsc_pkg::JMP_NOT_COLD;
        ctrl.target = PC_BASE;
      end
      // very cold extra terms
      5'd12: ctrl.alu = bsc_pkg::ALU_E7;
      5'd13: ctrl.alu = bsc_pkg::ALU_OFF_ADD;
      5'd14: ctrl.alu = bsc_pkg::ALU_E11;
      5'd15: ctrl.alu = bsc_pkg::ALU_SENS_ADD;
      // offset and sensitivity
      5'd16: ctrl.mul = bsc_pkg::MUL_DT_C4;
      5'd17: begin
        ctrl.alu = bsc_pkg::ALU_BIAS_P;
        ctrl.sh  = bsc_pkg::OFF_TC_SH;
        ctrl.mul = bsc_pkg::MUL_DT_C3;
      end
      5'd18: begin
        ctrl.alu = bsc_pkg::ALU_OFF_SUB;
        ctrl.sh  = bsc_pkg::OFF_TC_SH;
      end
      5'd19: ctrl.alu = bsc_pkg::ALU_OFF_SET;
      5'd20: begin
        ctrl.alu = bsc_pkg::ALU_BIAS_P;
        ctrl.sh  = bsc_pkg::SENS_TC_SH;
      end
      5'd21: begin
        ctrl.alu = bsc_pkg::ALU_SENS_SUB;
        ctrl.sh  = bsc_pkg::SENS_TC_SH;
      end
      5'd22: ctrl.alu = bsc_pkg::ALU_SENS_SET;
      // D1 * SENS in two partial products
      5'd23: ctrl.mul = bsc_pkg::MUL_RAW_SLO;
      5'd24: begin
        ctrl.alu = bsc_pkg::ALU_LD_P;
        ctrl.mul = bsc_pkg::MUL_RAW_SHI;
      end
      5'd25: ctrl.alu = bsc_pkg::ALU_ADD_PH;
      5'd26: begin
        ctrl.alu = bsc_pkg::ALU_BIAS_A;
        ctrl.sh  = bsc_pkg::DIV_PRESS_SH;
      end
      5'd27: begin
        ctrl.alu = bsc_pkg::ALU_OFF_SUB;
        ctrl.sh  = bsc_pkg::DIV_PRESS_SH;
      end
      5'd28: begin
        ctrl.alu = bsc_pkg::ALU_BIAS_A;
        ctrl.sh  = bsc_pkg::P_DIV_SH;
      end
      5'd29: begin
        ctrl.alu  = bsc_pkg::ALU_OUT_P;
        ctrl.sh   = bsc_pkg::P_DIV_SH;
        ctrl.done = 1'b1;
      end
      default: begin
        ctrl.jmp    = bsc_pkg::JMP_ALWAYS;
        ctrl.target = PC_DISPATCH;
      end
    endcase
  end

  // jump condition
  always_comb begin
    unique case (ctrl.jmp)
      bsc_pkg::JMP_NONE:     taken = 1'b0;
      bsc_pkg::JMP_ALWAYS:   taken = 1'b1;
      bsc_pkg::JMP_KIND:     taken = stat_i.kind;
      bsc_pkg::JMP_WARM:     taken = stat_i.warm;
      bsc_pkg::JMP_NOT_COLD: taken = stat_i.not_cold;
      default:               taken = 1'b0;
    endcase
  end

  // result step waits while the output register is full and stalled
  assign hold   = ctrl.done && stat_i.out_busy;
  assign exec   = busy_q && !hold;
  assign accept = in_valid_i && !busy_q;

  // step counter
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = PC_DISPATCH;
    end else if (exec) begin
      if (ctrl.done) begin
        busy_d = 1'b0;
        pc_d   = PC_DISPATCH;
      end else if (taken) begin
        pc_d = ctrl.target;
      end else begin
        pc_d = pc_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_DISPATCH;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign in_stall_o    = busy_q;
  assign ctrl_o        = ctrl;
  assign seq_o.accept  = accept;
  assign seq_o.exec    = exec;

endmodule

// ----- design/bsc_datapath.sv -----
`timescale 1ns / 1ps

module bsc_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_kind_i,
  input  logic [bsc_pkg::RAW_W-1:0]            in_raw_value_i,
  input  bsc_pkg::coef_t                       coef_i,
  input  bsc_pkg::ctrl_t                       ctrl_i,
  input  bsc_pkg::seq_t                        seq_i,
  output bsc_pkg::stat_t                       stat_o,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic                                 out_kind_echo_o,
  output logic signed [bsc_pkg::TEMP_W-1:0]    out_temperature_centi_o,
  output logic signed [bsc_pkg::PRESS_W-1:0]   out_pressure_pa_o
);

  localparam int TW = bsc_pkg::TEMP_W;
  localparam int AW = bsc_pkg::ACC_W;
  localparam int MW = bsc_pkg::MUL_W;
  localparam int PW = bsc_pkg::PROD_W;

  // item and state registers
  logic                            kind_q;
  logic [bsc_pkg::RAW_W-1:0]       raw_q;
  logic signed [bsc_pkg::DT_W-1:0] dt_q, dt_d;
  logic signed [TW-1:0]            tc_q, tc_d;
  logic [TW-1:0]                   t2_q, t2_d;

  // working registers
  logic signed [PW-1:0] p_q, p_d;
  logic signed [AW-1:0] a_q, a_d;
  logic signed [AW-1:0] off_q, off_d;
  logic signed [AW-1:0] sens_q, sens_d;

  // output register
  logic                             out_valid_q;
  logic                             out_kind_q;
  logic signed [TW-1:0]             out_temp_q, out_temp_d;
  logic signed [bsc_pkg::PRESS_W-1:0] out_press_q, out_press_d;

  logic signed [TW:0]   d_diff;
  logic signed [TW:0]   e_diff;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [AW-1:0] p_ext;
  logic signed [AW-1:0] bias_src;
  logic [AW-1:0]        bias_mask;
  logic signed [AW-1:0] a_sh;
  logic                 sat_hi, sat_lo;
  logic                 load;

  assign load = seq_i.exec;

  // distances from the correction thresholds
  assign d_diff = {tc_q[TW-1], tc_q} - {bsc_pkg::TEMP_BASE[TW-1], bsc_pkg::TEMP_BASE};
  assign e_diff = {tc_q[TW-1], tc_q} - {bsc_pkg::TEMP_COLD[TW-1], bsc_pkg::TEMP_COLD};

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctrl_i.mul)
      bsc_pkg::MUL_NONE: begin
        op_a = '0;
        op_b = '0;
      end
      bsc_pkg::MUL_DT_C6: begin
        op_a = {dt_q[bsc_pkg::DT_W-1], dt_q};
        op_b = {11'b0, coef_i.tsens};
      end
      bsc_pkg::MUL_DT_DT: begin
        op_a = {dt_q[bsc_pkg::DT_W-1], dt_q};
        op_b = {dt_q[bsc_pkg::DT_W-1], dt_q};
      end
      bsc_pkg::MUL_D_D: begin
        op_a = {{7{d_diff[TW]}}, d_diff};
        op_b = {{7{d_diff[TW]}}, d_diff};
      end
      bsc_pkg::MUL_E_E: begin
        op_a = {{7{e_diff[TW]}}, e_diff};
        op_b = {{7{e_diff[TW]}}, e_diff};
      end
      bsc_pkg::MUL_DT_C4: begin
        op_a = {dt_q[bsc_pkg::DT_W-1], dt_q};
        op_b = {11'b0, coef_i.offset_tc};
      end
      bsc_pkg::MUL_DT_C3: begin
        op_a = {dt_q[bsc_pkg::DT_W-1], dt_q};
        op_b = {11'b0, coef_i.sens_tc};
      end
      bsc_pkg::MUL_RAW_SLO: begin
        op_a = {3'b0, raw_q};
        op_b = {8'b0, sens_q[bsc_pkg::SENS_SPLIT-1:0]};
      end
      bsc_pkg::MUL_RAW_SHI: begin
        op_a = {3'b0, raw_q};
        op_b = sens_q[bsc_pkg::SENS_SPLIT+MW-1:bsc_pkg::SENS_SPLIT];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign p_d   = op_a * op_b;
  assign p_ext = {{(AW-PW){p_q[PW-1]}}, p_q};

  // truncation toward zero: add 2^sh - 1 to a negative value before the shift
  assign bias_src  = (ctrl_i.alu == bsc_pkg::ALU_BIAS_P) ? p_ext : a_q;
  assign bias_mask = ~({AW{1'b1}} << ctrl_i.sh);
  assign a_sh      = a_q >>> ctrl_i.sh;

  // 32-bit saturation of the shifted accumulator
  assign sat_hi = !a_sh[AW-1] && (a_sh[AW-2:bsc_pkg::PRESS_W-1] != '0);
  assign sat_lo = a_sh[AW-1] && (a_sh[AW-2:bsc_pkg::PRESS_W-1] != '1);

  // alu
  always_comb begin
    dt_d        = dt_q;
    tc_d        = tc_q;
    t2_d        = t2_q;
    a_d         = a_q;
    off_d       = off_q;
    sens_d      = sens_q;
    out_temp_d  = out_temp_q;
    out_press_d = out_press_q;
    unique case (ctrl_i.alu)
      bsc_pkg::ALU_NOP: ;
      bsc_pkg::ALU_DT:
        dt_d = {2'b0, raw_q} - {2'b0, coef_i.tref, 8'b0};
      bsc_pkg::ALU_TEMP:
        tc_d = a_sh[TW-1:0] + bsc_pkg::TEMP_BASE;
      bsc_pkg::ALU_CLR: begin
        off_d  = '0;
        sens_d = '0;
        t2_d   = '0;
      end
      bsc_pkg::ALU_T2:
        t2_d = p_q[bsc_pkg::T2_SH+TW-1:bsc_pkg::T2_SH];
      bsc_pkg::ALU_LD_P:
        a_d = p_ext;
      bsc_pkg::ALU_X5:
        a_d = (a_q <<< 2) + a_q;
      bsc_pkg::ALU_SPLIT5: begin
        off_d  = a_q >>> 1;
        sens_d = a_q >>> 2;
      end
      bsc_pkg::ALU_E7:
        a_d = (p_ext <<< 3) - p_ext;
      bsc_pkg::ALU_OFF_ADD:
        off_d = off_q + a_q;
      bsc_pkg::ALU_E11:
        a_d = a_q + (p_ext <<< 2);
      bsc_pkg::ALU_SENS_ADD:
        sens_d = sens_q + (a_q >>> 1);
      bsc_pkg::ALU_BIAS_P,
      bsc_pkg::ALU_BIAS_A:
        a_d = bias_src + (bias_src[AW-1] ? $signed(bias_mask) : $signed({AW{1'b0}}));
      bsc_pkg::ALU_OFF_SUB:
        a_d = a_sh - off_q;
      bsc_pkg::ALU_OFF_SET:
        off_d = a_q + $signed({32'b0, coef_i.offset, 16'b0});
      bsc_pkg::ALU_SENS_SUB:
        a_d = a_sh - sens_q;
      bsc_pkg::ALU_SENS_SET:
        sens_d = a_q + $signed({33'b0, coef_i.sens, 15'b0});
      bsc_pkg::ALU_ADD_PH:
        a_d = a_q + (p_ext <<< bsc_pkg::SENS_SPLIT);
      bsc_pkg::ALU_OUT_T: begin
        out_temp_d  = tc_q;
        out_press_d = '0;
      end
      bsc_pkg::ALU_OUT_P: begin
        out_temp_d = tc_q - $signed(t2_q);
        priority if (sat_hi) begin
          out_press_d = 32'sh7FFF_FFFF;
        end else if (sat_lo) begin
          out_press_d = 32'sh8000_0000;
        end else begin
          out_press_d = a_sh[bsc_pkg::PRESS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // stored compensation state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q        <= '0;
      tc_q        <= bsc_pkg::TEMP_BASE;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        dt_q <= dt_d;
        tc_q <= tc_d;
      end
      if (load && ctrl_i.done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture, working registers and result payload
  always_ff @(posedge clk_i) begin
    if (seq_i.accept) begin
      kind_q <= in_kind_i;
      raw_q  <= in_raw_value_i;
    end
    if (load) begin
      t2_q   <= t2_d;
      a_q    <= a_d;
      off_q  <= off_d;
      sens_q <= sens_d;
      if (ctrl_i.mul != bsc_pkg::MUL_NONE) begin
        p_q <= p_d;
      end
    end
    if (load && ctrl_i.done) begin
      out_kind_q  <= kind_q;
      out_temp_q  <= out_temp_d;
      out_press_q <= out_press_d;
    end
  end

  assign stat_o.kind     = kind_q;
  assign stat_o.warm     = !(tc_q < bsc_pkg::TEMP_BASE);
  assign stat_o.not_cold = !(tc_q < bsc_pkg::TEMP_COLD);
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o             = out_valid_q;
  assign out_kind_echo_o         = out_kind_q;
  assign out_temperature_centi_o = out_temp_q;
  assign out_pressure_pa_o       = out_press_q;

endmodule

// ----- design/baro_sensor_compensation_core.sv -----
`timescale 1ns / 1ps

// Barometric sensor compensation core.
// Input channel (in_valid_i / in_stall_o): one beat per raw 24-bit conversion,
// in_kind_i = 0 for a temperature reading, 1 for a pressure reading.
// Output channel (out_valid_o / out_stall_i): one beat per input beat with the
// kind echoed, temperature in 0.01 degC and pressure in Pa (zero on
// temperature beats, saturated to 32 bits on pressure beats).
// Calibration words C1..C6 are written through cfg_we_i / cfg_idx_i /
// cfg_data_i at indexes 0..5; other indexes are ignored. The user must write
// them only while the core is idle; the block itself does not enforce it. A
// microcoded sequencer steps one shared 27x27 multiplier and a 64-bit
// accumulator, one control word per cycle unless the result step holds on a
// stalled output, and takes one item at a time. Pressure beats add second
// order terms when the stored temperature is below 20.00 degC and extra terms
// below -15.00 degC. Reset clears the calibration words, the stored dT to
// zero and the stored temperature to 20.00 degC. While the receiver stalls, a
// result waits in the output register and the next item runs up to its result
// step and holds there.

module baro_sensor_compensation_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // calibration write port
  input  logic                                cfg_we_i,
  input  logic [bsc_pkg::IDX_W-1:0]           cfg_idx_i,
  input  logic [bsc_pkg::COEF_W-1:0]          cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                in_kind_i,
  input  logic [bsc_pkg::RAW_W-1:0]           in_raw_value_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                out_kind_echo_o,
  output logic signed [bsc_pkg::TEMP_W-1:0]   out_temperature_centi_o,
  output logic signed [bsc_pkg::PRESS_W-1:0]  out_pressure_pa_o
);

  bsc_pkg::coef_t coef_q;
  bsc_pkg::ctrl_t ctrl;
  bsc_pkg::seq_t  seq;
  bsc_pkg::stat_t stat;

  // calibration register bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bsc_pkg::REG_SENS:      coef_q.sens      <= cfg_data_i;
        bsc_pkg::REG_OFFSET:    coef_q.offset    <= cfg_data_i;
        bsc_pkg::REG_SENS_TC:   coef_q.sens_tc   <= cfg_data_i;
        bsc_pkg::REG_OFFSET_TC: coef_q.offset_tc <= cfg_data_i;
        bsc_pkg::REG_TREF:      coef_q.tref      <= cfg_data_i;
        bsc_pkg::REG_TSENS:     coef_q.tsens     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step counter and control store
  bsc_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .seq_o      (seq)
  );

  // multiplier, accumulator and result register
  bsc_datapath u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_kind_i               (in_kind_i),
    .in_raw_value_i          (in_raw_value_i),
    .coef_i                  (coef_q),
    .ctrl_i                  (ctrl),
    .seq_i                   (seq),
    .stat_o                  (stat),
    .out_stall_i             (out_stall_i),
    .out_valid_o             (out_valid_o),
    .out_kind_echo_o         (out_kind_echo_o),
    .out_temperature_centi_o (out_temperature_centi_o),
    .out_pressure_pa_o       (out_pressure_pa_o)
  );

endmodule

// ----- tb/baro_sensor_compensation_core_test.sv -----
`timescale 1ns / 1ps

module baro_sensor_compensation_core_test;

  // beat kinds
  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  // register indexes past the calibration block, writes there are dropped
  localparam logic [bsc_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bsc_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // compensation constants
  localparam longint TEMP_REF    = 64'sd2000;
  localparam longint TEMP_FROST  = -64'sd1500;
  localparam longint TREF_SCALE  = 64'sd256;
  localparam longint TEMP_DIV    = 64'sd8388608;
  localparam longint T2_DIV      = 64'sd2147483648;
  localparam longint OFF_SCALE   = 64'sd65536;
  localparam longint OFF_TC_DIV  = 64'sd128;
  localparam longint SENS_SCALE  = 64'sd32768;
  localparam longint SENS_TC_DIV = 64'sd256;
  localparam longint PRESS_DIV   = 64'sd2097152;
  localparam longint P_DIV       = 64'sd32768;
  localparam longint PRESS_MAX   = 64'sd2147483647;
  localparam longint PRESS_MIN   = -64'sd2147483648;
  localparam longint RAW_MAX     = 64'sd16777215;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int END_WAIT    = 40;

  typedef logic [bsc_pkg::COEF_W-1:0]          coef_word_t;
  typedef logic [bsc_pkg::RAW_W-1:0]           raw_word_t;
  typedef logic signed [bsc_pkg::DT_W-1:0]     dt_word_t;
  typedef logic signed [bsc_pkg::TEMP_W-1:0]   temp_word_t;
  typedef logic signed [bsc_pkg::PRESS_W-1:0]  press_word_t;

  typedef struct {
    logic        kind;
    temp_word_t  temp;
    press_word_t press;
  } reading_t;

  // predicts each compensated reading and matches it against the core output
  class reading_scoreboard;
    coef_word_t coef [6];
    dt_word_t   stored_dt;
    temp_word_t stored_temp;
    reading_t   expected_readings [$];
    int         mismatches;

    function new();
      foreach (coef[i]) coef[i] = '0;
      stored_dt   = '0;
      stored_temp = 19'sd2000;
      mismatches  = 0;
    endfunction

    function void set_coef(logic [bsc_pkg::IDX_W-1:0] idx, coef_word_t value);
      if (idx <= bsc_pkg::REG_TSENS) coef[idx] = value;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // work out the reading caused by one accepted conversion
    function void note_conversion(logic kind, raw_word_t raw);
      longint   r, c1, c2, c3, c4, c5, c6;
      longint   dt, t, d, e, t2, off2, sens2, off, sens, p;
      reading_t rd;
      r  = longint'(raw);
      c1 = longint'(coef[bsc_pkg::REG_SENS]);
      c2 = longint'(coef[bsc_pkg::REG_OFFSET]);
      c3 = longint'(coef[bsc_pkg::REG_SENS_TC]);
      c4 = longint'(coef[bsc_pkg::REG_OFFSET_TC]);
      c5 = longint'(coef[bsc_pkg::REG_TREF]);
      c6 = longint'(coef[bsc_pkg::REG_TSENS]);
      rd.kind = kind;
      if (kind == KIND_TEMP) begin
        dt = r - c5 * TREF_SCALE;
        t  = TEMP_REF + (dt * c6) / TEMP_DIV;
        stored_dt   = dt_word_t'(dt);
        stored_temp = temp_word_t'(t);
        rd.temp  = temp_word_t'(t);
        rd.press = '0;
      end else begin
        dt    = longint'(stored_dt);
        t     = longint'(stored_temp);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        // second order correction below 20 degC, extra terms when very cold
        if (t < TEMP_REF) begin
          d     = t - TEMP_REF;
          t2    = (dt * dt) / T2_DIV;
          off2  = (5 * d * d) / 2;
          sens2 = (5 * d * d) / 4;
          if (t < TEMP_FROST) begin
            e     = t - TEMP_FROST;
            off2  = off2 + 7 * e * e;
            sens2 = sens2 + (11 * e * e) / 2;
          end
        end
        off  = c2 * OFF_SCALE + (c4 * dt) / OFF_TC_DIV - off2;
        sens = c1 * SENS_SCALE + (c3 * dt) / SENS_TC_DIV - sens2;
        p    = ((r * sens) / PRESS_DIV - off) / P_DIV;
        if (p > PRESS_MAX) p = PRESS_MAX;
        else if (p < PRESS_MIN) p = PRESS_MIN;
        rd.temp  = temp_word_t'(t - t2);
        rd.press = press_word_t'(p);
      end
      expected_readings.push_back(rd);
    endfunction

    // compare one output beat with the oldest prediction
    function void check_reading(logic kind, temp_word_t temp, press_word_t press);
      reading_t rd;
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: kind_echo %0d temperature_centi %0d pressure_pa %0d",
               kind, temp, press);
        mismatches++;
        return;
      end
      rd = expected_readings.pop_front();
      if (kind !== rd.kind) begin
        $error("kind_echo mismatch: expected %0d, got %0d", rd.kind, kind);
        mismatches++;
      end
      if (temp !== rd.temp) begin
        $error("temperature_centi mismatch: expected %0d, got %0d", rd.temp, temp);
        mismatches++;
      end
      if (press !== rd.press) begin
        $error("pressure_pa mismatch: expected %0d, got %0d", rd.press, press);
        mismatches++;
      end
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [bsc_pkg::IDX_W-1:0]         cfg_idx_i = '0;
  coef_word_t                        cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic                              in_kind_i = 1'b0;
  raw_word_t                         in_raw_value_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic                              out_kind_echo_o;
  temp_word_t                        out_temperature_centi_o;
  press_word_t                       out_pressure_pa_o;

  reading_scoreboard sb = new();
  bit                idle_on = 1'b1;
  coef_word_t        cur_tref = '0;
  int                stall_left = 0;
  int                cycle_count = 0;

  baro_sensor_compensation_core DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_kind_i              (in_kind_i),
    .in_raw_value_i         (in_raw_value_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_kind_echo_o        (out_kind_echo_o),
    .out_temperature_centi_o(out_temperature_centi_o),
    .out_pressure_pa_o      (out_pressure_pa_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output side: check accepted beats, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_reading(out_kind_echo_o, out_temperature_centi_o, out_pressure_pa_o);
    if (!idle_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = int'($urandom_range(0, 4));
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // one calibration write
  task automatic write_coef(input logic [bsc_pkg::IDX_W-1:0] idx, input coef_word_t value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_coef(idx, value);
  endtask

  // full calibration set, plus writes to the unused indexes
  task automatic set_calibration(input coef_word_t c1, input coef_word_t c2,
                                 input coef_word_t c3, input coef_word_t c4,
                                 input coef_word_t c5, input coef_word_t c6);
    write_coef(bsc_pkg::REG_SENS, c1);
    write_coef(bsc_pkg::REG_OFFSET, c2);
    write_coef(bsc_pkg::REG_SENS_TC, c3);
    write_coef(bsc_pkg::REG_OFFSET_TC, c4);
    write_coef(bsc_pkg::REG_TREF, c5);
    write_coef(bsc_pkg::REG_TSENS, c6);
    write_coef(REG_SPARE_LO, coef_word_t'($urandom));
    write_coef(REG_SPARE_HI, coef_word_t'($urandom));
    cfg_we_i <= 1'b0;
    cur_tref = c5;
  endtask

  // send one conversion beat, with an occasional gap before it
  task automatic put_beat(input logic kind, input raw_word_t raw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_kind_i      <= kind;
    in_raw_value_i <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_conversion(kind, raw);
  endtask

  // wait until every predicted reading has come out
  task automatic drain_readings();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // temperature reading, mostly around the reference point
  function automatic raw_word_t temp_raw();
    longint span, v;
    case ($urandom_range(0, 5))
      0: v = longint'(raw_word_t'($urandom));
      1: v = $urandom_range(0, 1) ? RAW_MAX : 64'sd0;
      default: begin
        span = longint'(1) << $urandom_range(8, 23);
        v = longint'(cur_tref) * TREF_SCALE
            + longint'($urandom_range(0, 32'(2 * span))) - span;
        if (v < 0) v = 0;
        else if (v > RAW_MAX) v = RAW_MAX;
      end
    endcase
    return raw_word_t'(v);
  endfunction

  function automatic raw_word_t press_raw();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? raw_word_t'(RAW_MAX) : '0;
    return raw_word_t'($urandom);
  endfunction

  // mostly temperature followed by a few pressures, some loose beats
  task automatic run_random(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        put_beat(KIND_TEMP, temp_raw());
        sent++;
        repeat ($urandom_range(1, 3)) begin
          put_beat(KIND_PRESS, press_raw());
          sent++;
        end
      end else begin
        put_beat(1'($urandom_range(0, 1)), raw_word_t'($urandom));
        sent++;
      end
    end
    drain_readings();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pressure straight after reset, calibration still cleared
    put_beat(KIND_PRESS, 24'd9085466);
    drain_readings();

    // typical calibration, pressure before any temperature
    set_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    put_beat(KIND_PRESS, 24'd9085466);
    put_beat(KIND_PRESS, 24'd0);
    // nominal room temperature, repeated pressure
    put_beat(KIND_TEMP, 24'd8569150);
    put_beat(KIND_PRESS, 24'd9085466);
    put_beat(KIND_PRESS, 24'd9085466);
    // very cold end of the range
    put_beat(KIND_TEMP, 24'd0);
    put_beat(KIND_PRESS, 24'hFFFFFF);
    put_beat(KIND_PRESS, 24'd0);
    put_beat(KIND_PRESS, 24'd9085466);
    // hot end of the range
    put_beat(KIND_TEMP, 24'hFFFFFF);
    put_beat(KIND_PRESS, 24'hFFFFFF);
    put_beat(KIND_PRESS, 24'd0);
    // cool, between the two thresholds
    put_beat(KIND_TEMP, 24'd8066784);
    put_beat(KIND_PRESS, 24'd9085466);
    // exactly at 20 degC, just below it, exactly at -15 degC
    put_beat(KIND_TEMP, 24'd8566784);
    put_beat(KIND_PRESS, 24'd9085466);
    put_beat(KIND_TEMP, 24'd8566487);
    put_beat(KIND_PRESS, 24'd9085466);
    put_beat(KIND_TEMP, 24'd7529763);
    put_beat(KIND_PRESS, 24'd9085466);
    put_beat(KIND_TEMP, 24'd7529764);
    put_beat(KIND_PRESS, 24'd9085466);
    run_random(350);

    // calibration extremes
    set_calibration('0, '0, '0, '0, '0, '0);
    run_random(200);
    set_calibration('1, '1, '1, '1, '1, '1);
    run_random(250);

    // random calibration sets
    repeat (2) begin
      set_calibration(coef_word_t'($urandom), coef_word_t'($urandom),
                      coef_word_t'($urandom), coef_word_t'($urandom),
                      coef_word_t'($urandom), coef_word_t'($urandom));
      run_random(300);
    end

    // closing stretch without any idling
    idle_on = 1'b0;
    repeat (2) begin
      set_calibration(coef_word_t'($urandom), coef_word_t'($urandom),
                      coef_word_t'($urandom), coef_word_t'($urandom),
                      coef_word_t'($urandom), coef_word_t'($urandom));
      run_random(250);
    end

    repeat (END_WAIT) @(posedge clk_i);
    if (sb.pending() != 0) $error("%0d readings never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
